@@ rtl/mapc_pkg.sv @@
// mapc_pkg: shared types and constants of the mass-action propensity core
// used by the register block, controller, datapath, top level and checker
// no dependencies
package mapc_pkg;

  localparam int CNT_W     = 16;   // species_count field width
  localparam int ORD_W     = 4;    // reaction_order field width
  localparam int RATE_W    = 32;
  localparam int PROD_W    = 64;
  localparam int HALF_W    = 32;
  localparam int ACC_W     = 128;
  localparam int DIGIT_W   = 8;    // quotient bits per divide cycle
  localparam int DIV_W     = 72;   // dividend bits, a multiple of DIGIT_W
  localparam int DIV_STEPS = DIV_W / DIGIT_W;
  localparam int MUL_STEPS = 4;    // 32x32 partial products per 64x64 multiply
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int CYC_W     = 4;

  localparam logic [0:0] REG_RATE = 1'b0;
  localparam logic [0:0] REG_INF  = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] species_count;
    logic [ORD_W-1:0] reaction_order;
    logic             last_reactant;
  } in_item_t;

  typedef struct packed {
    logic [PROD_W-1:0] propensity;
    logic              overflowed;
    logic              infinite;
  } out_item_t;

  typedef enum logic {
    SEL_BIN,
    SEL_PROD
  } mul_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     prep;
    logic     mul_ld;
    mul_sel_t mul_sel;
    logic     mul_go;
    logic     acc_go;
    logic [1:0] pp_idx;
    logic     div_chk;
    logic     div_go;
    logic     bin_upd;
    logic     prod_fin;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic bin_done;
    logic div_sat;
    logic last;
  } stat_t;

endpackage

@@ rtl/mapc_regs.sv @@
// mapc_regs: configuration registers behind the apb-style port
// depends on mapc_pkg
module mapc_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mapc_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [mapc_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [mapc_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output logic [mapc_pkg::RATE_W-1:0] rate_constant,
  output logic                        constant_is_infinite
);

  logic [mapc_pkg::RATE_W-1:0] rate_r;
  logic                        inf_r;
  logic                        wr_en;

  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= '0;
      inf_r  <= 1'b0;
    end else if (wr_en) begin
      case (cfg_paddr[2])
        mapc_pkg::REG_RATE: rate_r <= cfg_pwdata[mapc_pkg::RATE_W-1:0];
        mapc_pkg::REG_INF:  inf_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      mapc_pkg::REG_RATE: cfg_prdata = rate_r;
      mapc_pkg::REG_INF:  cfg_prdata = {{(mapc_pkg::DATA_W-1){1'b0}}, inf_r};
      default:            cfg_prdata = '0;
    endcase
  end

  assign rate_constant        = rate_r;
  assign constant_is_infinite = inf_r;

endmodule

@@ rtl/mapc_ctrl.sv @@
// mapc_ctrl: sequencer for the binomial loop, shared multiplier and divider
// depends on mapc_pkg
module mapc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  mapc_pkg::stat_t stat,
  output mapc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_BCHK,
    ST_BMUL,
    ST_BDLD,
    ST_BDIV,
    ST_BUPD,
    ST_PMUL,
    ST_PFIN,
    ST_EMIT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [mapc_pkg::CYC_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_BCHK;
      end
      ST_BCHK: begin
        cmd.mul_ld = 1'b1;
        cnt_nxt    = '0;
        if (stat.bin_done) begin
          cmd.mul_sel = mapc_pkg::SEL_PROD;
          state_nxt   = ST_PMUL;
        end else begin
          cmd.mul_sel = mapc_pkg::SEL_BIN;
          state_nxt   = ST_BMUL;
        end
      end
      ST_BMUL, ST_PMUL: begin
        // partial products issue in counts 0..3 and accumulate in counts 1..4
        cmd.mul_go = (cnt_r < mapc_pkg::CYC_W'(mapc_pkg::MUL_STEPS));
        cmd.acc_go = (cnt_r != '0);
        cmd.pp_idx = cnt_r[1:0];
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == mapc_pkg::CYC_W'(mapc_pkg::MUL_STEPS)) begin
          state_nxt = (state_r == ST_BMUL) ? ST_BDLD : ST_PFIN;
        end
      end
      ST_BDLD: begin
        cmd.div_chk = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = stat.div_sat ? ST_BCHK : ST_BDIV;
      end
      ST_BDIV: begin
        cmd.div_go = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == mapc_pkg::CYC_W'(mapc_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_BUPD;
        end
      end
      ST_BUPD: begin
        cmd.bin_upd = 1'b1;
        state_nxt   = ST_BCHK;
      end
      ST_PFIN: begin
        cmd.prod_fin = 1'b1;
        state_nxt    = stat.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/mapc_dp.sv @@
// mapc_dp: datapath with group state, shared 32x32 multiplier and radix-256 divider
// depends on mapc_pkg; driven by mapc_ctrl
module mapc_dp #(
  parameter int COUNT_BITS = 16,
  parameter int MAX_ORDER  = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mapc_pkg::in_item_t          in_data,
  input  logic [mapc_pkg::RATE_W-1:0] rate_constant,
  input  logic                        constant_is_infinite,
  input  mapc_pkg::cmd_t              cmd,
  output mapc_pkg::stat_t             stat,
  output mapc_pkg::out_item_t         out_data
);

  localparam int CW   = (COUNT_BITS < mapc_pkg::CNT_W) ? COUNT_BITS : mapc_pkg::CNT_W;
  localparam int KMAX = (MAX_ORDER < 15) ? MAX_ORDER : 15;
  localparam int PW   = mapc_pkg::PROD_W;
  localparam int HW   = mapc_pkg::HALF_W;
  localparam int AW   = mapc_pkg::ACC_W;
  localparam int DW   = mapc_pkg::DIV_W;
  localparam int GW   = mapc_pkg::DIGIT_W;
  localparam int OW   = mapc_pkg::ORD_W;

  logic [CW-1:0]  n_r, m_r;
  logic [OW-1:0]  k_r;
  logic [OW:0]    j_r;
  logic           last_r;
  logic [PW-1:0]  ans_r;
  logic           bsat_r;
  logic [PW-1:0]  rp_r;
  logic           ovf_r;
  logic           in_group_r;
  logic [PW-1:0]  a_r, b_r;
  logic [AW-1:0]  acc_r;
  logic [PW-1:0]  pp_r;
  logic [1:0]     sh_r;
  logic [DW-1:0]  div_r;
  logic [OW-1:0]  rem_r;
  mapc_pkg::out_item_t out_r;

  logic [OW-1:0]  k_in;
  logic [CW-1:0]  k_ext, nmk;
  logic [HW-1:0]  a_half, b_half;
  logic [GW-1:0]  q_digit;
  logic [OW-1:0]  rem_new;
  logic [OW:0]    trial;
  logic           prod_ovf;

  // clamp the order
  assign k_in  = (in_data.reaction_order > OW'(KMAX)) ? OW'(KMAX) : in_data.reaction_order;
  assign k_ext = CW'(k_r);
  assign nmk   = n_r - k_ext;

  assign a_half = cmd.pp_idx[0] ? a_r[PW-1:HW] : a_r[HW-1:0];
  assign b_half = cmd.pp_idx[1] ? b_r[PW-1:HW] : b_r[HW-1:0];

  // one quotient byte per cycle: eight narrow restoring steps
  always_comb begin
    rem_new = rem_r;
    q_digit = '0;
    trial   = '0;
    for (int i = 0; i < GW; i++) begin
      trial = {rem_new, div_r[DW-1-i]};
      if (trial >= {1'b0, j_r[OW-1:0]}) begin
        trial      = trial - {1'b0, j_r[OW-1:0]};
        q_digit[GW-1-i] = 1'b1;
      end
      rem_new = trial[OW-1:0];
    end
  end

  assign prod_ovf      = |acc_r[AW-1:PW];
  assign stat.bin_done = (j_r > {1'b0, k_r}) || bsat_r;
  assign stat.div_sat  = (acc_r[AW-1:PW] >= PW'(j_r));
  assign stat.last     = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_group_r <= 1'b0;
      rp_r       <= '0;
      ovf_r      <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        n_r    <= in_data.species_count[CW-1:0];
        k_r    <= k_in;
        last_r <= in_data.last_reactant;
        if (!in_group_r) begin
          rp_r       <= PW'(rate_constant);
          ovf_r      <= 1'b0;
          in_group_r <= 1'b1;
        end
      end
      if (cmd.prep) begin
        j_r    <= (OW+1)'(1);
        m_r    <= n_r;
        bsat_r <= 1'b0;
        if (n_r < k_ext) begin
          ans_r <= '0;
          k_r   <= '0;
        end else begin
          ans_r <= PW'(1);
          if (k_ext > nmk) begin
            k_r <= nmk[OW-1:0];
          end
        end
      end
      if (cmd.mul_ld) begin
        acc_r <= '0;
        if (cmd.mul_sel == mapc_pkg::SEL_PROD) begin
          a_r <= rp_r;
          b_r <= ans_r;
        end else begin
          a_r <= ans_r;
          b_r <= PW'(m_r);
        end
      end
      if (cmd.mul_go) begin
        pp_r <= a_half * b_half;
        sh_r <= {1'b0, cmd.pp_idx[0]} + {1'b0, cmd.pp_idx[1]};
      end
      if (cmd.acc_go) begin
        acc_r <= acc_r + (AW'(pp_r) << {sh_r, 5'b0});
      end
      if (cmd.div_chk) begin
        if (stat.div_sat) begin
          ans_r  <= '1;
          bsat_r <= 1'b1;
        end else begin
          div_r <= acc_r[DW-1:0];
          rem_r <= '0;
        end
      end
      if (cmd.div_go) begin
        div_r <= {div_r[DW-GW-1:0], q_digit};
        rem_r <= rem_new;
      end
      if (cmd.bin_upd) begin
        ans_r <= div_r[PW-1:0];
        m_r   <= m_r - 1'b1;
        j_r   <= j_r + 1'b1;
      end
      if (cmd.prod_fin) begin
        rp_r  <= prod_ovf ? '1 : acc_r[PW-1:0];
        ovf_r <= ovf_r | prod_ovf | bsat_r;
      end
      if (cmd.emit) begin
        in_group_r <= 1'b0;
        if (constant_is_infinite) begin
          out_r.propensity <= '1;
          out_r.overflowed <= 1'b0;
          out_r.infinite   <= 1'b1;
        end else begin
          out_r.propensity <= rp_r;
          out_r.overflowed <= ovf_r;
          out_r.infinite   <= 1'b0;
        end
      end
    end
  end

  assign out_data = out_r;

endmodule

@@ rtl/mass_action_propensity_core.sv @@
// mass_action_propensity_core: top level of the mass-action propensity core
// depends on mapc_pkg, mapc_regs, mapc_ctrl, mapc_dp
//
// usage: a reaction arrives as a group of input beats on in_*, one per
// reactant (species count, order, last flag). each beat's binomial C(n,k)
// is multiplied into a running product that starts at rate_constant
// (Q16.16, register 0); the beat marked last produces one result beat on
// out_* with the Q48.16 propensity, a saturation flag and the infinite
// flag (register 1 forces an all-ones infinite result).
// each beat runs up to k = min(order, count-order) binomial steps; each
// step multiplies on the shared 32x32 multiplier and then divides on the
// byte-wide divider, and the product update takes the multiplier again. one
// beat is in work at a time; in_ready is high only between beats.
// the result sits in an output register: the next group is accepted while
// it waits, and a stalled receiver only holds the core at the next result.
// reset (rst_n low, synchronous) clears the config registers, empties the
// output register and closes any open group.
module mass_action_propensity_core #(
  parameter int COUNT_BITS = 16,
  parameter int MAX_ORDER  = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mapc_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mapc_pkg::out_item_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mapc_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [mapc_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [mapc_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  logic [mapc_pkg::RATE_W-1:0] rate_constant;
  logic                        constant_is_infinite;
  mapc_pkg::cmd_t              cmd;
  mapc_pkg::stat_t             stat;

  mapc_regs u_regs (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready),
    .rate_constant        (rate_constant),
    .constant_is_infinite (constant_is_infinite)
  );

  mapc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mapc_dp #(
    .COUNT_BITS (COUNT_BITS),
    .MAX_ORDER  (MAX_ORDER)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_data              (in_data),
    .rate_constant        (rate_constant),
    .constant_is_infinite (constant_is_infinite),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_data             (out_data)
  );

endmodule

@@ rtl/mapc_chk.sv @@
// mapc_chk: port-level checks of the mass-action propensity core, bound to the top
// depends on mapc_pkg and mass_action_propensity_core
module mapc_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mapc_pkg::out_item_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // infinite result is all ones with no overflow flag
  a_inf_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.infinite ||
      (out_data.propensity == '1 && !out_data.overflowed))
    else $error("malformed infinite result");

  // the core is busy and raises no new result right after taking a beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid))
    else $error("core ready or emitting right after accept");

  // reset empties the output
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind mass_action_propensity_core mapc_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
